[hw/rtl/tqm_pkg.sv]
// Shared types and constants for the three-queue timestamp merge.
`default_nettype none

package tqm_pkg;

   localparam int NUM_QUEUES          = 3;
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int ID_W                = 31;
   localparam int AMOUNT_W            = 32;
   localparam int TIME_W              = 32;
   localparam int CHAN_W              = 2;
   localparam int COUNT_W             = 5;
   localparam int SHIPPED_W           = 16;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_TAKE    = 1'b1;

   localparam logic [CHAN_W-1:0] CH_SITE   = 2'd0;
   localparam logic [CHAN_W-1:0] CH_APP    = 2'd1;
   localparam logic [CHAN_W-1:0] CH_MARKET = 2'd2;

   localparam logic [SHIPPED_W-1:0] SHIPPED_MAX = '1;

   typedef struct packed {
      logic                operation;
      logic [CHAN_W-1:0]   channel;
      logic [ID_W-1:0]     order_id;
      logic [AMOUNT_W-1:0] amount_cents;
      logic [TIME_W-1:0]   timestamp;
   } req_type;

   typedef struct packed {
      logic                 item_valid;
      logic [ID_W-1:0]      out_order_id;
      logic [CHAN_W-1:0]    out_channel;
      logic [AMOUNT_W-1:0]  out_amount_cents;
      logic [TIME_W-1:0]    out_timestamp;
      logic                 overflow;
      logic [COUNT_W-1:0]   site_count;
      logic [COUNT_W-1:0]   app_count;
      logic [COUNT_W-1:0]   market_count;
      logic [SHIPPED_W-1:0] shipped_count;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]     order_id;
      logic [AMOUNT_W-1:0] amount_cents;
      logic [TIME_W-1:0]   timestamp;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic enq;
      logic take;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[hw/rtl/tqm_ctrl.sv]
// Controller: sequences capture and commit of one beat at a time.
`default_nettype none

module tqm_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_operation,
   output logic              req_stall,
   output tqm_pkg::cmd_type  cmd,
   input  tqm_pkg::sts_type  sts
);
   import tqm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ENQ  = 3'b010,
      ST_TAKE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_stall   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_operation == OP_TAKE) ? ST_TAKE : ST_ENQ;
            end
         end
         ST_ENQ: begin
            if (sts.out_free) begin
               cmd.enq  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_TAKE: begin
            if (sts.out_free) begin
               cmd.take = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/tqm_datapath.sv]
// Datapath: queue memories, pointers, head compare and result register.
`default_nettype none

module tqm_datapath #(
   parameter int QUEUE_DEPTH = tqm_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  tqm_pkg::cmd_type  cmd,
   output tqm_pkg::sts_type  sts,
   input  tqm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output tqm_pkg::rsp_type  rsp_data
);
   import tqm_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      advance = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   req_type              in_ff;
   logic [PTR_W-1:0]     head_ff [NUM_QUEUES];
   logic [PTR_W-1:0]     head_in [NUM_QUEUES];
   logic [PTR_W-1:0]     tail_ff [NUM_QUEUES];
   logic [PTR_W-1:0]     tail_in [NUM_QUEUES];
   logic [CNT_W-1:0]     cnt_ff  [NUM_QUEUES];
   logic [CNT_W-1:0]     cnt_in  [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] wr_en;
   entry_type            rd_ff   [NUM_QUEUES];
   entry_type            wr_entry;
   logic [SHIPPED_W-1:0] shipped_ff, shipped_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 found;
   logic [CHAN_W-1:0]    best;
   entry_type            best_entry;
   logic                 overflow;
   logic                 hit;

   assign wr_entry = '{order_id: in_ff.order_id, amount_cents: in_ff.amount_cents,
                       timestamp: in_ff.timestamp};

   for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_queue
      entry_type mem [QUEUE_DEPTH];
      always_ff @(posedge clock) begin
         if (wr_en[g]) begin
            mem[tail_ff[g]] <= wr_entry;
         end
         rd_ff[g] <= mem[head_ff[g]];
      end
   end

   // earliest head; lower channel wins ties
   always_comb begin
      found      = (cnt_ff[0] != '0);
      best       = CH_SITE;
      best_entry = rd_ff[0];
      for (int q = 1; q < NUM_QUEUES; q++) begin
         if ((cnt_ff[q] != '0) && (!found || (rd_ff[q].timestamp < best_entry.timestamp))) begin
            found      = 1'b1;
            best       = CHAN_W'(q);
            best_entry = rd_ff[q];
         end
      end
   end

   assign hit = cmd.take && found;

   always_comb begin
      overflow   = 1'b0;
      shipped_in = shipped_ff;
      wr_en      = '0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
         head_in[q] = head_ff[q];
         tail_in[q] = tail_ff[q];
         cnt_in[q]  = cnt_ff[q];
         if (cmd.enq && (in_ff.channel == CHAN_W'(q))) begin
            if (cnt_ff[q] == CNT_W'(QUEUE_DEPTH)) begin
               overflow = 1'b1;
            end else begin
               wr_en[q]   = 1'b1;
               tail_in[q] = advance(tail_ff[q]);
               cnt_in[q]  = cnt_ff[q] + 1'b1;
            end
         end
         if (hit && (best == CHAN_W'(q))) begin
            head_in[q] = advance(head_ff[q]);
            cnt_in[q]  = cnt_ff[q] - 1'b1;
         end
      end
      if (hit && (shipped_ff != SHIPPED_MAX)) begin
         shipped_in = shipped_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_data_in                  = '0;
      rsp_data_in.item_valid       = hit;
      rsp_data_in.out_order_id     = hit ? best_entry.order_id : '0;
      rsp_data_in.out_channel      = hit ? best : '0;
      rsp_data_in.out_amount_cents = hit ? best_entry.amount_cents : '0;
      rsp_data_in.out_timestamp    = hit ? best_entry.timestamp : '0;
      rsp_data_in.overflow         = overflow;
      rsp_data_in.site_count       = COUNT_W'(cnt_in[0]);
      rsp_data_in.app_count        = COUNT_W'(cnt_in[1]);
      rsp_data_in.market_count     = COUNT_W'(cnt_in[2]);
      rsp_data_in.shipped_count    = shipped_in;
   end

   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_ff <= req_data;
      end
      if (cmd.enq || cmd.take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= '0;
            tail_ff[q] <= '0;
            cnt_ff[q]  <= '0;
         end
         shipped_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= head_in[q];
            tail_ff[q] <= tail_in[q];
            cnt_ff[q]  <= cnt_in[q];
         end
         shipped_ff <= shipped_in;
         if (cmd.enq || cmd.take) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[hw/rtl/three_queue_timestamp_merge.sv]
// Top level: three order queues merged by timestamp, one result beat per request beat.
//
//   channel   direction  ports                          payload
//   req       in         req_valid / req_stall          tqm_pkg::req_type
//   rsp       out        rsp_valid / rsp_stall          tqm_pkg::rsp_type
//
// Each beat is accepted, then committed into the result register; the commit state
// follows accept because of the registered read of the three queue-head memories.
// Next request beat is taken the cycle after commit, while the result may still wait.
// A stalled result holds the commit of the following beat until it is taken.
// Reset is synchronous and clears pointers, counts, the shipped counter and the result
// valid flag only; queue memories are not cleared and need no clearing pass.
`default_nettype none

module three_queue_timestamp_merge #(
   parameter int QUEUE_DEPTH = tqm_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  tqm_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output tqm_pkg::rsp_type  rsp_data
);
   import tqm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tqm_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .cmd           (cmd),
      .sts           (sts)
   );

   tqm_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.enq || cmd.take) |-> sts.out_free)
      else $error("commit while result register busy");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.enq, cmd.take}))
      else $error("more than one command");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat accepted before commit");

   a_take_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.item_valid && rsp_data.overflow))
      else $error("taken order flagged as overflow");

endmodule

`default_nettype wire
